FILE: hdl/dirty_rect_tracker_top_macros.svh
// Assertion helpers shared by the tracker modules.
`ifndef DIRTY_RECT_TRACKER_TOP_MACROS_SVH
`define DIRTY_RECT_TRACKER_TOP_MACROS_SVH
// Implication that must hold at every edge outside reset.
`define DRT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Implication checked in the cycle after the antecedent.
`define DRT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

FILE: hdl/drt_pkg.sv
// ---------------------------------------------------------------------------
// drt_pkg
// Types and codes shared by the dirty rectangle tracker.
// ---------------------------------------------------------------------------
package drt_pkg;
  localparam int unsigned CoordW = 16;
  localparam int unsigned EdgeW  = 18;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_TAKE  = 2'd1,
    OP_RESET = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_TAKEN     = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_COLLAPSED = 3'd4
  } status_t;

  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
  } box_t;

  // datapath commands
  typedef struct packed {
    logic prep;        // align and clamp input box, load into candidate
    logic push_cand;   // push candidate onto stack
    logic pop_req;     // issue stack read at top-1
    logic pop_load;    // load candidate from stack read data
    logic tab_req;     // issue table read at scan index
    logic tab_check;   // compare candidate to table read data, push fragments
    logic scan_inc;
    logic scan_clr;
    logic append;      // write candidate at rect_count
    logic collapse;
    logic take_req;    // read entry rect_count-1
    logic take_load;   // latch taken box, decrement count
    logic clr_count;
  } cmd_t;

  typedef struct packed {
    logic prep_drop;
    logic stack_empty;
    logic push_busy;
    logic cand_empty;
    logic scan_done;
    logic hit;
    logic push_fail;
    logic table_full;
    logic count_zero;
  } sts_t;
endpackage

FILE: hdl/drt_ram.sv
// ---------------------------------------------------------------------------
// drt_ram
// Single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module drt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/drt_datapath.sv
// ---------------------------------------------------------------------------
// drt_datapath
// Rectangle table, fragment stack, candidate register and overlap splitter.
// ---------------------------------------------------------------------------
`include "dirty_rect_tracker_top_macros.svh"
module drt_datapath #(
  parameter int unsigned MAX_RECTS  = 64,
  parameter int unsigned WORK_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  drt_pkg::cmd_t             cmd,
  output drt_pkg::sts_t             sts,
  input  logic [15:0]               in_x,
  input  logic [15:0]               in_y,
  input  logic [15:0]               in_w,
  input  logic [15:0]               in_h,
  input  logic [15:0]               frame_w,
  input  logic [15:0]               frame_h,
  output drt_pkg::box_t             taken,
  output logic [$clog2(MAX_RECTS+1)-1:0] count
);
  import drt_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_RECTS + 1);
  localparam int unsigned TabA = $clog2(MAX_RECTS);
  localparam int unsigned StkW = $clog2(WORK_DEPTH + 1);
  localparam int unsigned StkA = $clog2(WORK_DEPTH);

  logic [CntW-1:0] count_r;
  logic [StkW-1:0] top_r;
  logic [CntW-1:0] scan_r;
  box_t            cand_r;
  box_t            taken_r;
  logic            drop_r;
  logic            hit_r;
  logic            fail_r;

  // table ram
  logic            tab_we;
  logic [TabA-1:0] tab_wa, tab_ra;
  box_t            tab_wd;
  logic [63:0]     tab_rd;
  // stack ram
  logic            stk_we;
  logic [StkA-1:0] stk_wa, stk_ra;
  box_t            stk_wd;
  logic [63:0]     stk_rd;

  box_t r;
  logic ovl;
  logic [15:0] mt, mb;
  logic f_above, f_below, f_left, f_right;
  logic [2:0] nfrag;
  logic [StkW+2:0] need;
  box_t frag [4];
  logic [3:0] fsel;

  // prep arithmetic
  logic [EdgeW-1:0] rt_raw, bt_raw, rt_al, bt_al;
  logic [15:0] lft, tp, rt_c, bt_c;
  logic [EdgeW-1:0] lft2, tp2;

  assign r = box_t'(tab_rd);

  always_comb begin
    rt_raw = EdgeW'(in_x) + EdgeW'(in_w);
    bt_raw = EdgeW'(in_y) + EdgeW'(in_h);
    rt_al  = (rt_raw[3:0] != 4'd0) ? ((rt_raw | EdgeW'(15)) + EdgeW'(1)) : rt_raw;
    bt_al  = bt_raw[0] ? (bt_raw + EdgeW'(1)) : bt_raw;
    lft    = {in_x[15:4], 4'd0};
    tp     = {in_y[15:1], 1'b0};
    rt_c   = (rt_al > EdgeW'(frame_w)) ? frame_w : rt_al[15:0];
    bt_c   = (bt_al > EdgeW'(frame_h)) ? frame_h : bt_al[15:0];
    lft2   = EdgeW'(lft) + EdgeW'(2);
    tp2    = EdgeW'(tp) + EdgeW'(2);
  end

  always_comb begin
    ovl = (cand_r.left < r.right) && (cand_r.top < r.bottom) &&
          (r.left < cand_r.right) && (r.top < cand_r.bottom);
    mt  = (cand_r.top > r.top) ? cand_r.top : r.top;
    mb  = (cand_r.bottom < r.bottom) ? cand_r.bottom : r.bottom;
    f_right = cand_r.right > r.right;
    f_left  = cand_r.left < r.left;
    f_below = cand_r.bottom > r.bottom;
    f_above = cand_r.top < r.top;
    frag[0] = '{left: r.right, top: mt, right: cand_r.right, bottom: mb};
    frag[1] = '{left: cand_r.left, top: mt, right: r.left, bottom: mb};
    frag[2] = '{left: cand_r.left, top: r.bottom, right: cand_r.right,
                bottom: cand_r.bottom};
    frag[3] = '{left: cand_r.left, top: cand_r.top, right: cand_r.right, bottom: r.top};
    fsel  = {f_above, f_below, f_left, f_right};
    nfrag = 3'(f_right) + 3'(f_left) + 3'(f_below) + 3'(f_above);
    need  = (StkW+3)'(top_r) + (StkW+3)'(nfrag);
  end

  // fragment writes go one per cycle via a small pending queue, unless a candidate push holds the write port
  logic [3:0] pend_r;
  box_t       pbox_r [4];
  logic [1:0] pidx;

  always_comb begin
    pidx = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (pend_r[i]) begin
        pidx = 2'(i);
      end
    end
  end

  always_comb begin
    stk_we = 1'b0;
    stk_wa = top_r[StkA-1:0];
    stk_wd = cand_r;
    if (cmd.push_cand) begin
      stk_we = 1'b1;
    end else if (pend_r != 4'd0) begin
      stk_we = 1'b1;
      stk_wd = pbox_r[pidx];
    end
    // hold the popped address while the read data is pending
    stk_ra = cmd.pop_req ? StkA'(top_r - StkW'(1)) : top_r[StkA-1:0];
    tab_we = cmd.append || cmd.collapse;
    tab_wa = cmd.collapse ? '0 : count_r[TabA-1:0];
    tab_wd = cmd.collapse ? '{left: 16'd0, top: 16'd0, right: frame_w, bottom: frame_h}
                          : cand_r;
    tab_ra = cmd.take_req ? TabA'(count_r - CntW'(1)) : scan_r[TabA-1:0];
  end

  drt_ram #(.WIDTH(64), .DEPTH(MAX_RECTS)) u_tab (
    .clk(clk), .we(tab_we), .waddr(tab_wa), .wdata(tab_wd),
    .raddr(tab_ra), .rdata(tab_rd)
  );

  drt_ram #(.WIDTH(64), .DEPTH(WORK_DEPTH)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
    .raddr(stk_ra), .rdata(stk_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      top_r   <= '0;
      scan_r  <= '0;
      pend_r  <= '0;
      hit_r   <= 1'b0;
      fail_r  <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      if (cmd.prep) begin
        cand_r <= '{left: lft, top: tp, right: rt_c, bottom: bt_c};
        drop_r <= (EdgeW'(rt_c) < lft2) || (EdgeW'(bt_c) < tp2);
        top_r  <= '0;
      end
      if (cmd.push_cand) begin
        top_r <= top_r + StkW'(1);
      end else if (pend_r != 4'd0) begin
        top_r <= top_r + StkW'(1);
        pend_r[pidx] <= 1'b0;
      end
      if (cmd.pop_req) begin
        top_r <= top_r - StkW'(1);
      end
      if (cmd.pop_load) begin
        cand_r <= box_t'(stk_rd);
      end
      if (cmd.scan_clr) begin
        scan_r <= '0;
        hit_r  <= 1'b0;
        fail_r <= 1'b0;
      end
      if (cmd.scan_inc) begin
        scan_r <= scan_r + CntW'(1);
      end
      if (cmd.tab_check) begin
        hit_r <= ovl;
        if (ovl) begin
          if (need > (StkW+3)'(WORK_DEPTH)) begin
            fail_r <= 1'b1;
          end else begin
            pend_r <= fsel;
            for (int i = 0; i < 4; i++) begin
              pbox_r[i] <= frag[i];
            end
          end
        end
      end
      if (cmd.append) begin
        count_r <= count_r + CntW'(1);
      end
      if (cmd.clr_count) begin
        count_r <= '0;
      end
      if (cmd.collapse) begin
        count_r <= CntW'(1);
        top_r   <= '0;
        pend_r  <= '0;
      end
      if (cmd.take_load) begin
        taken_r <= r;
        count_r <= count_r - CntW'(1);
      end
    end
  end

  always_comb begin
    sts.prep_drop   = drop_r;
    sts.stack_empty = (top_r == '0) && (pend_r == 4'd0);
    sts.push_busy   = (pend_r != 4'd0);
    sts.cand_empty  = (cand_r.left >= cand_r.right) || (cand_r.top >= cand_r.bottom);
    sts.scan_done   = (scan_r >= count_r);
    sts.hit         = hit_r;
    sts.push_fail   = fail_r;
    sts.table_full  = (count_r >= CntW'(MAX_RECTS));
    sts.count_zero  = (count_r == '0);
  end

  assign taken = taken_r;
  assign count = count_r;

  `DRT_ASSERT_IMP(a_count_range, 1'b1, count_r <= CntW'(MAX_RECTS))
  `DRT_ASSERT_IMP(a_stack_range, 1'b1, top_r <= StkW'(WORK_DEPTH))
  `DRT_ASSERT_NXT(a_collapse_one, cmd.collapse, count_r == CntW'(1))
endmodule

FILE: hdl/drt_ctrl.sv
// ---------------------------------------------------------------------------
// drt_ctrl
// Sequencer for add, take and reset operations.
// ---------------------------------------------------------------------------
`include "dirty_rect_tracker_top_macros.svh"
module drt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  drt_pkg::op_t      op,
  input  drt_pkg::sts_t     sts,
  input  logic              out_free,
  output drt_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              done,
  output drt_pkg::status_t  status
);
  import drt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_CHK, S_PUSH, S_POP, S_POPW, S_LOAD, S_TREQ, S_TWAIT,
    S_TCHK, S_DEC, S_TAKE, S_TAKEW, S_TLOAD, S_DONE
  } state_t;

  state_t  state_r;
  status_t status_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_PREP:  cmd.prep = 1'b1;
      S_PUSH:  cmd.push_cand = 1'b1;
      S_POP:   cmd.pop_req = !sts.stack_empty && !sts.push_busy;
      S_LOAD:  begin
        cmd.pop_load = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      S_TREQ:  cmd.tab_req = 1'b1;
      S_TCHK:  begin
        cmd.tab_check = 1'b1;
        cmd.scan_inc  = 1'b1;
      end
      S_DEC:   begin
        if (sts.push_fail) begin
          cmd.collapse = 1'b1;
        end else if (!sts.cand_empty && !sts.hit && sts.scan_done) begin
          if (sts.table_full) begin
            cmd.collapse = 1'b1;
          end else begin
            cmd.append = 1'b1;
          end
        end
      end
      S_TAKE, S_TAKEW: cmd.take_req = 1'b1;
      S_TLOAD: cmd.take_load = 1'b1;
      S_IDLE:  cmd.clr_count = in_fire && (op == OP_RESET);
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_DROPPED;
    end else begin
      case (state_r)
        S_IDLE: if (in_fire) begin
          case (op)
            OP_ADD, OP_RESET: state_r <= S_PREP;
            OP_TAKE: begin
              if (sts.count_zero) begin
                status_r <= ST_EMPTY;
                state_r  <= S_DONE;
              end else begin
                state_r <= S_TAKE;
              end
            end
            default: begin
              status_r <= ST_DROPPED;
              state_r  <= S_DONE;
            end
          endcase
        end
        S_PREP: state_r <= S_CHK;
        S_CHK: begin
          if (sts.prep_drop) begin
            status_r <= ST_DROPPED;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: state_r <= S_POP;
        S_POP: begin
          if (sts.stack_empty) begin
            status_r <= ST_ADDED;
            state_r  <= S_DONE;
          end else if (!sts.push_busy) begin
            state_r <= S_POPW;
          end
        end
        S_POPW: state_r <= S_LOAD;
        S_LOAD: state_r <= S_TREQ;
        S_TREQ: begin
          if (sts.cand_empty || sts.scan_done) begin
            state_r <= S_DEC;
          end else begin
            state_r <= S_TWAIT;
          end
        end
        S_TWAIT: state_r <= S_TCHK;
        S_TCHK: state_r <= S_DEC;
        S_DEC: begin
          if (sts.push_fail || (!sts.cand_empty && !sts.hit && sts.scan_done &&
              sts.table_full)) begin
            status_r <= ST_COLLAPSED;
            state_r  <= S_DONE;
          end else if (sts.hit || sts.cand_empty || sts.scan_done) begin
            state_r <= S_POP;
          end else begin
            state_r <= S_TREQ;
          end
        end
        S_TAKE: state_r <= S_TAKEW;
        S_TAKEW: state_r <= S_TLOAD;
        S_TLOAD: begin
          status_r <= ST_TAKEN;
          state_r  <= S_DONE;
        end
        S_DONE: if (out_free) begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state_r != S_IDLE);
  assign done   = (state_r == S_DONE) && out_free;
  assign status = status_r;

  `DRT_ASSERT_NXT(a_fire_leaves_idle, in_fire && !busy, busy)
  `DRT_ASSERT_IMP(a_no_fire_busy, busy, !in_fire)
endmodule

FILE: hdl/dirty_rect_tracker_top.sv
// Operations run one at a time: the input is not ready while one is in
//   progress, and an add scans the table for each fragment it checks.
//   A finished result waits while the output register is full.
// Reset (rst_n low, synchronous): table and stack empty, frame 640 x 480.
// ---------------------------------------------------------------------------
// dirty_rect_tracker_top
// Dirty rectangle table with stream input, stream result and config port.
// ---------------------------------------------------------------------------
module dirty_rect_tracker_top #(
  parameter int unsigned MAX_RECTS  = 64,
  parameter int unsigned WORK_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[1:0], rect_x[17:2], rect_y[33:18], rect_width[49:34],
  // rect_height[65:50], zero fill
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], out_x[18:3], out_y[34:19], out_width[50:35],
  // out_height[66:51], entries_left[73:67], zero fill
  output logic [79:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import drt_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_RECTS + 1);

  logic [15:0] frame_w_r, frame_h_r;
  cmd_t  cmd;
  sts_t  sts;
  box_t  taken;
  logic [CntW-1:0] count;
  logic  busy, done, in_fire, out_free;
  op_t   in_op;
  status_t status;
  logic        ovalid_r;
  logic [79:0] odata_r;
  logic [15:0] ox, oy, ow, oh;
  logic [15:0] arg_x_r, arg_y_r, arg_w_r, arg_h_r;

  assign in_op     = op_t'(in_tdata[1:0]);
  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !ovalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= 16'd640;
      frame_h_r <= 16'd480;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) begin
        frame_w_r <= cfg_wdata;
      end else begin
        frame_h_r <= cfg_wdata;
      end
    end
  end

  // hold the operands of the accepted transfer, or the full frame for a reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (in_op == OP_RESET) begin
        arg_x_r <= 16'd0;
        arg_y_r <= 16'd0;
        arg_w_r <= frame_w_r;
        arg_h_r <= frame_h_r;
      end else begin
        arg_x_r <= in_tdata[17:2];
        arg_y_r <= in_tdata[33:18];
        arg_w_r <= in_tdata[49:34];
        arg_h_r <= in_tdata[65:50];
      end
    end
  end

  drt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .op(in_op),
    .sts(sts), .out_free(out_free), .cmd(cmd), .busy(busy), .done(done),
    .status(status)
  );

  drt_datapath #(.MAX_RECTS(MAX_RECTS), .WORK_DEPTH(WORK_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_x(arg_x_r), .in_y(arg_y_r),
    .in_w(arg_w_r), .in_h(arg_h_r),
    .frame_w(frame_w_r), .frame_h(frame_h_r), .taken(taken), .count(count)
  );

  always_comb begin
    ox = 16'd0;
    oy = 16'd0;
    ow = 16'd0;
    oh = 16'd0;
    if (status == ST_TAKEN) begin
      ox = taken.left;
      oy = taken.top;
      ow = taken.right - taken.left;
      oh = taken.bottom - taken.top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (done) begin
      ovalid_r <= 1'b1;
      odata_r  <= {6'd0, 7'(count), oh, ow, oy, ox, status};
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
endmodule
